[src/glyph_text_renderer_defines.svh]
// Assertion macros used by the checker of the glyph text renderer.
`ifndef GLYPH_TEXT_RENDERER_DEFINES_SVH
`define GLYPH_TEXT_RENDERER_DEFINES_SVH

// Consequence must hold in the same cycle as the antecedent.
`define GTR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("glyph text renderer check failed");

// Consequence must hold in the cycle after the antecedent.
`define GTR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("glyph text renderer check failed");

`endif

[src/gtr_pkg.sv]
// Shared types, codes and helpers of the glyph text renderer.
`timescale 1ns / 1ps
`default_nettype none

package gtr_pkg;

    // Action codes of an input item.
    localparam logic [1:0] ACT_DEFINE = 2'd0;
    localparam logic [1:0] ACT_LOAD   = 2'd1;
    localparam logic [1:0] ACT_DRAW   = 2'd2;
    localparam logic [1:0] ACT_PEN    = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DRAW_COLOR   = 2'd2;

    localparam int COORD_W = 18;
    localparam int ROW_W   = 32;

    // One glyph metrics entry, with width and height already saturated.
    typedef struct packed {
        logic [5:0]        width;
        logic [5:0]        height;
        logic signed [7:0] off_x;
        logic signed [7:0] off_y;
        logic signed [7:0] adv_x;
        logic signed [7:0] adv_y;
    } glyph_metric_t;

    function automatic logic [COORD_W-1:0] sx8(input logic [7:0] v);
        return {{(COORD_W-8){v[7]}}, v};
    endfunction

    function automatic logic [COORD_W-1:0] sx16(input logic [15:0] v);
        return {{(COORD_W-16){v[15]}}, v};
    endfunction

endpackage

`default_nettype wire

[src/gtr_col_window.sv]
// Column window: which of the 32 glyph columns land inside the image.
`timescale 1ns / 1ps
`default_nettype none

module gtr_col_window import gtr_pkg::*; (
    input  wire logic signed [COORD_W-1:0] col_lo,
    input  wire logic signed [COORD_W-1:0] col_hi,
    output logic [ROW_W-1:0]               col_mask
);

    // Glyph column j is visible when col_lo <= j < col_hi; bit 31 is column 0.
    always_comb begin
        for (int j = 0; j < ROW_W; j++) begin
            col_mask[ROW_W-1-j] = ($signed(COORD_W'(j)) >= col_lo) &&
                                  ($signed(COORD_W'(j)) < col_hi);
        end
    end

endmodule

`default_nettype wire

[src/glyph_text_renderer.sv]
// Top level of the glyph text renderer: glyph tables, pen and row sequencer.
`timescale 1ns / 1ps
`default_nettype none

// The renderer keeps a glyph table of GLYPH_COUNT entries, each with metrics
// (width, height, box offsets, pen advance) and up to MAX_GLYPH_HEIGHT bitmap
// rows of 32 pixels, bit 31 leftmost. Define, row load and set-pen items
// leave the block ready again in the next cycle. A draw item for a defined
// glyph keeps the block busy until the pen has advanced. One 18-bit adder is
// shared by every coordinate step (first column, clip bounds, top row,
// per-row increment and the two pen advances) under a small sequencer, and
// each glyph row takes a state for the row memory read and then a state to
// load the output register, which waits while the result side stalls. A
// draw of an undefined glyph, or a code beyond the table, emits nothing and
// leaves the pen alone. Each result item gives the top-down
// image row, the image column of glyph column zero, the row pixels clipped to
// the image, the current draw color and a flag on the final row. Rows that
// fall outside the image still come out, with an empty mask. The metrics
// table resets to all undefined through per-entry valid flags; the bitmap
// rows are not cleared by reset, so a glyph should have its rows loaded
// before it is drawn. Configuration registers are written on cfg_wr_en and
// should only change while the block is idle with no results outstanding.
module glyph_text_renderer import gtr_pkg::*; #(
    parameter int GLYPH_COUNT      = 256,
    parameter int MAX_GLYPH_WIDTH  = 32,
    parameter int MAX_GLYPH_HEIGHT = 32
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Configuration write port.
    input  wire logic                      cfg_wr_en,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [23:0]               cfg_wr_data,
    // Input items.
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [1:0]                s_action,
    input  wire logic [7:0]                s_glyph_code,
    input  wire logic [4:0]                s_row_index,
    input  wire logic [31:0]               s_row_bits,
    input  wire logic [5:0]                s_glyph_width,
    input  wire logic [5:0]                s_glyph_height,
    input  wire logic signed [7:0]         s_offset_x,
    input  wire logic signed [7:0]         s_offset_y,
    input  wire logic signed [7:0]         s_advance_x,
    input  wire logic signed [7:0]         s_advance_y,
    input  wire logic signed [15:0]        s_pen_x,
    input  wire logic signed [15:0]        s_pen_y,
    // Result items.
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [COORD_W-1:0]      m_image_row,
    output logic signed [COORD_W-1:0]      m_first_column,
    output logic [ROW_W-1:0]               m_pixel_mask,
    output logic [23:0]                    m_pixel_color,
    output logic                           m_last_row
);

    localparam int CODE_AW    = $clog2(GLYPH_COUNT);
    localparam int ROW_DEPTH  = GLYPH_COUNT * MAX_GLYPH_HEIGHT;
    localparam int ROW_AW     = $clog2(ROW_DEPTH);
    localparam int WIDTH_CAP  = (MAX_GLYPH_WIDTH < 32) ? MAX_GLYPH_WIDTH : 32;
    localparam int HEIGHT_CAP = (MAX_GLYPH_HEIGHT < 32) ? MAX_GLYPH_HEIGHT : 32;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_FC   = 4'd1;
    localparam logic [3:0] ST_LO   = 4'd2;
    localparam logic [3:0] ST_HI   = 4'd3;
    localparam logic [3:0] ST_T1   = 4'd4;
    localparam logic [3:0] ST_T2   = 4'd5;
    localparam logic [3:0] ST_T3   = 4'd6;
    localparam logic [3:0] ST_RD   = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;
    localparam logic [3:0] ST_ADVX = 4'd9;
    localparam logic [3:0] ST_ADVY = 4'd10;

    logic [3:0]                 state_reg, state_next;

    logic [12:0]                iw_reg;
    logic [12:0]                ih_reg;
    logic [23:0]                color_reg;
    logic signed [15:0]         pen_x_reg;
    logic signed [15:0]         pen_y_reg;

    logic [GLYPH_COUNT-1:0]     defined_reg;
    glyph_metric_t              met_mem [GLYPH_COUNT];
    glyph_metric_t              met_rd_reg;
    logic [ROW_W-1:0]           row_mem [ROW_DEPTH];
    logic [ROW_W-1:0]           row_rd_reg;

    logic [ROW_AW-1:0]          addr_reg;
    logic [5:0]                 cnt_reg;
    logic signed [COORD_W-1:0]  fc_reg;
    logic signed [COORD_W-1:0]  lo_reg;
    logic signed [COORD_W-1:0]  hi_reg;
    logic signed [COORD_W-1:0]  row_reg;
    logic [ROW_W-1:0]           col_mask_reg;
    logic [ROW_W-1:0]           col_mask;

    logic                       m_valid_reg;
    logic signed [COORD_W-1:0]  m_image_row_reg;
    logic signed [COORD_W-1:0]  m_first_column_reg;
    logic [ROW_W-1:0]           m_pixel_mask_reg;
    logic [23:0]                m_pixel_color_reg;
    logic                       m_last_row_reg;

    logic                       s_accept;
    logic                       code_ok;
    logic                       row_ok;
    logic [CODE_AW-1:0]         code_idx;
    logic [ROW_AW-1:0]          base_addr;
    logic [ROW_AW-1:0]          ld_addr;
    glyph_metric_t              met_wr;
    logic                       out_free;
    logic                       last_now;
    logic                       row_in_image;
    logic [ROW_W-1:0]           width_mask;

    // Shared adder operands.
    logic [COORD_W-1:0]         alu_a;
    logic [COORD_W-1:0]         alu_b;
    logic                       alu_sub;
    logic [COORD_W-1:0]         alu_sum;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign code_ok   = (9'(s_glyph_code) < 9'(GLYPH_COUNT));
    assign row_ok    = (7'(s_row_index) < 7'(MAX_GLYPH_HEIGHT));
    assign code_idx  = s_glyph_code[CODE_AW-1:0];
    assign base_addr = ROW_AW'(code_idx) * ROW_AW'(MAX_GLYPH_HEIGHT);
    assign ld_addr   = base_addr + ROW_AW'(s_row_index);
    assign out_free  = !m_valid_reg || m_ready;
    assign last_now  = ((cnt_reg + 6'd1) == met_rd_reg.height);

    // New metrics entry, with width and height saturated to the table limits.
    always_comb begin
        met_wr.width  = (s_glyph_width > 6'(WIDTH_CAP)) ? 6'(WIDTH_CAP) : s_glyph_width;
        met_wr.height = (s_glyph_height > 6'(HEIGHT_CAP)) ? 6'(HEIGHT_CAP)
                                                          : s_glyph_height;
        met_wr.off_x  = s_offset_x;
        met_wr.off_y  = s_offset_y;
        met_wr.adv_x  = s_advance_x;
        met_wr.adv_y  = s_advance_y;
    end

    // The shared coordinate adder. Each sequencer state picks its operands;
    // subtraction is done as a plus the inverse of b plus one.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (state_reg)
            ST_FC: begin
                alu_a = sx16(pen_x_reg);
                alu_b = sx8(met_rd_reg.off_x);
            end
            ST_LO: begin
                alu_b   = fc_reg;
                alu_sub = 1'b1;
            end
            ST_HI: begin
                alu_a   = {5'd0, iw_reg};
                alu_b   = fc_reg;
                alu_sub = 1'b1;
            end
            ST_T1: begin
                alu_a   = {5'd0, ih_reg};
                alu_b   = sx16(pen_y_reg);
                alu_sub = 1'b1;
            end
            ST_T2: begin
                alu_a   = row_reg;
                alu_b   = sx8(met_rd_reg.off_y);
                alu_sub = 1'b1;
            end
            ST_T3: begin
                alu_a   = row_reg;
                alu_b   = {12'd0, met_rd_reg.height};
                alu_sub = 1'b1;
            end
            ST_OUT: begin
                alu_a = row_reg;
                alu_b = COORD_W'(1);
            end
            ST_ADVX: begin
                alu_a = sx16(pen_x_reg);
                alu_b = sx8(met_rd_reg.adv_x);
            end
            ST_ADVY: begin
                alu_a = sx16(pen_y_reg);
                alu_b = sx8(met_rd_reg.adv_y);
            end
            default: begin
                alu_a = '0;
            end
        endcase
        alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + COORD_W'(alu_sub);
    end

    gtr_col_window u_col_window (
        .col_lo   (lo_reg),
        .col_hi   (hi_reg),
        .col_mask (col_mask)
    );

    // A row is drawn only if it lies between the top and bottom of the image.
    assign row_in_image = !row_reg[COORD_W-1] &&
                          ({1'b0, row_reg[COORD_W-2:0]} < {5'd0, ih_reg});
    // Columns at or past the glyph width carry no pixels.
    assign width_mask   = ~(32'hFFFF_FFFF >> met_rd_reg.width);

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_action == ACT_DRAW) && code_ok && defined_reg[code_idx]) begin
                    state_next = ST_FC;
                end
            end
            ST_FC:   state_next = ST_LO;
            ST_LO:   state_next = ST_HI;
            ST_HI:   state_next = ST_T1;
            ST_T1:   state_next = ST_T2;
            ST_T2:   state_next = ST_T3;
            ST_T3:   state_next = (met_rd_reg.height == 6'd0) ? ST_ADVX : ST_RD;
            ST_RD:   state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = last_now ? ST_ADVX : ST_RD;
                end
            end
            ST_ADVX: state_next = ST_ADVY;
            ST_ADVY: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state, pen and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            defined_reg <= '0;
            pen_x_reg   <= '0;
            pen_y_reg   <= '0;
            iw_reg      <= 13'd640;
            ih_reg      <= 13'd480;
            color_reg   <= 24'hFF_FFFF;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  iw_reg    <= cfg_wr_data[12:0];
                    CFG_IMAGE_HEIGHT: ih_reg    <= cfg_wr_data[12:0];
                    CFG_DRAW_COLOR:   color_reg <= cfg_wr_data;
                    default:          color_reg <= color_reg;
                endcase
            end
            if (s_accept && (s_action == ACT_PEN)) begin
                pen_x_reg <= s_pen_x;
                pen_y_reg <= s_pen_y;
            end
            if (s_accept && (s_action == ACT_DEFINE) && code_ok) begin
                defined_reg[code_idx] <= 1'b1;
            end
            if (state_reg == ST_ADVX) begin
                pen_x_reg <= $signed(alu_sum[15:0]);
            end
            if (state_reg == ST_ADVY) begin
                pen_y_reg <= $signed(alu_sum[15:0]);
            end
            if ((state_reg == ST_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Metrics table: one write and one registered read port.
    always_ff @(posedge aclk) begin
        if (s_accept && (s_action == ACT_DEFINE) && code_ok) begin
            met_mem[code_idx] <= met_wr;
        end
        if (s_accept) begin
            met_rd_reg <= met_mem[code_idx];
        end
    end

    // Bitmap rows: written by row loads while idle, read during a draw.
    always_ff @(posedge aclk) begin
        if (s_accept && (s_action == ACT_LOAD) && code_ok && row_ok) begin
            row_mem[ld_addr] <= s_row_bits;
        end
        if (state_reg == ST_RD) begin
            row_rd_reg <= row_mem[addr_reg];
        end
    end

    // Coordinate registers, row walk and the output register.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            addr_reg <= base_addr;
            cnt_reg  <= 6'd0;
        end
        unique case (state_reg)
            ST_FC: fc_reg  <= $signed(alu_sum);
            ST_LO: lo_reg  <= $signed(alu_sum);
            ST_HI: hi_reg  <= $signed(alu_sum);
            ST_T1: row_reg <= $signed(alu_sum);
            ST_T2: row_reg <= $signed(alu_sum);
            ST_T3: begin
                row_reg      <= $signed(alu_sum);
                col_mask_reg <= col_mask;
            end
            ST_OUT: begin
                if (out_free) begin
                    row_reg            <= $signed(alu_sum);
                    addr_reg           <= addr_reg + ROW_AW'(1);
                    cnt_reg            <= cnt_reg + 6'd1;
                    m_image_row_reg    <= row_reg;
                    m_first_column_reg <= fc_reg;
                    m_pixel_mask_reg   <= row_in_image ? (row_rd_reg & width_mask & col_mask_reg)
                                                       : '0;
                    m_pixel_color_reg  <= color_reg;
                    m_last_row_reg     <= last_now;
                end
            end
            default: begin
                fc_reg <= fc_reg;
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_image_row    = m_image_row_reg;
    assign m_first_column = m_first_column_reg;
    assign m_pixel_mask   = m_pixel_mask_reg;
    assign m_pixel_color  = m_pixel_color_reg;
    assign m_last_row     = m_last_row_reg;

endmodule

`default_nettype wire

[src/gtr_checker.sv]
// Port-level checks of the glyph text renderer and their binding.
`timescale 1ns / 1ps
`default_nettype none
`include "glyph_text_renderer_defines.svh"

module gtr_checker import gtr_pkg::*; (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_valid,
    input wire logic                      s_ready,
    input wire logic [1:0]                s_action,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic signed [COORD_W-1:0] m_image_row,
    input wire logic [ROW_W-1:0]          m_pixel_mask,
    input wire logic                      m_last_row
);

    // Table loads and pen moves never hold the input side up.
    `GTR_ASSERT_NEXT(a_quick_items, s_valid && s_ready && (s_action != ACT_DRAW), s_ready)

    // While a glyph is only partly delivered, no new item is taken.
    `GTR_ASSERT_SAME(a_busy_mid_glyph, m_valid && !m_last_row, !s_ready)

    // A result waiting on the consumer keeps its row, mask and last-row flag.
    `GTR_ASSERT_NEXT(a_result_held, m_valid && !m_ready,
        m_valid && $stable(m_image_row) && $stable(m_pixel_mask) && $stable(m_last_row))

endmodule

bind glyph_text_renderer gtr_checker u_gtr_checker (.*);

`default_nettype wire
